// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/elrm_pkg.sv =====
package elrm_pkg;

  localparam int LOG_DEPTH_DEF  = 256;
  localparam int INDEX_BITS_DEF = 16;

  typedef enum logic [1:0] {
    FN_INS = 2'd0,
    FN_REM = 2'd1,
    FN_MAP = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  // Control part of the query token moving down the cell chain.
  typedef struct packed {
    logic    valid;
    status_t status;
  } tok_ctl_t;

endpackage

// ===== design/edit_log_index_remapper.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// command  | start / busy            | func, op_index, op_size, from_version,
//          |                         | to_version, query_index
// result   | done (one-cycle strobe) | mapped_index, status, log_length
//
// Appends, unused codes and rejected mappings: result in the cycle after accept,
// busy stays low.
// Mappings: the query token walks the entry cells one per cycle; busy is high
// while the token walks the chain and falls as the result appears.
// Reset (rst, synchronous): empties the log and clears the chain tokens.
// Results cannot be stalled; done marks each one for exactly one cycle.
`include "assert_macros.svh"

module edit_log_index_remapper #(
  parameter int LOG_DEPTH  = elrm_pkg::LOG_DEPTH_DEF,
  parameter int INDEX_BITS = elrm_pkg::INDEX_BITS_DEF,
  parameter int CNT_W      = $clog2(LOG_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [INDEX_BITS-1:0] op_index,
  input  logic [INDEX_BITS-1:0] op_size,
  input  logic [CNT_W-1:0]      from_version,
  input  logic [CNT_W-1:0]      to_version,
  input  logic [INDEX_BITS-1:0] query_index,
  output logic                  done,
  output logic [INDEX_BITS-1:0] mapped_index,
  output logic [2:0]            status,
  output logic [CNT_W-1:0]      log_length
);
  import elrm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MAP  = 2'b10
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      from_q;
  logic [CNT_W-1:0]      to_q;

  tok_ctl_t              launch_ctl;
  logic [INDEX_BITS-1:0] launch_pos;
  tok_ctl_t              tok_ctl [0:LOG_DEPTH];
  logic [INDEX_BITS-1:0] tok_pos [0:LOG_DEPTH];

  func_t                 fn;
  logic                  accept;
  logic                  full;
  logic                  range_bad;
  logic                  wr_en;

  assign busy      = (state == S_MAP);
  assign accept    = start && !busy;
  assign fn        = func_t'(func);
  assign full      = (count == CNT_W'(LOG_DEPTH));
  assign range_bad = (from_version > to_version) || (to_version > count);
  assign wr_en     = accept && (fn == FN_INS || fn == FN_REM) && !full;

  assign tok_ctl[0] = launch_ctl;
  assign tok_pos[0] = launch_pos;

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    elrm_cell #(
      .INDEX_BITS(INDEX_BITS),
      .CNT_W     (CNT_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_ptr   (count),
      .wr_remove(fn == FN_REM),
      .wr_start (op_index),
      .wr_len   (op_size),
      .from_q   (from_q),
      .to_q     (to_q),
      .in_ctl   (tok_ctl[i]),
      .in_pos   (tok_pos[i]),
      .out_ctl  (tok_ctl[i+1]),
      .out_pos  (tok_pos[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      launch_ctl <= '0;
    end else begin
      count <= count_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            log_length   <= count_next;
            mapped_index <= '0;
            case (fn)
              FN_INS, FN_REM: begin
                done   <= 1'b1;
                status <= full ? ST_FULL : ST_OK;
              end
              FN_MAP: begin
                if (range_bad) begin
                  done   <= 1'b1;
                  status <= ST_RANGE;
                end else begin
                  launch_ctl <= '{valid: 1'b1, status: ST_OK};
                  launch_pos <= query_index;
                  from_q     <= from_version;
                  to_q       <= to_version;
                  state      <= S_MAP;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_OK;
              end
            endcase
          end
        end
        S_MAP: begin
          launch_ctl <= '0;
          if (tok_ctl[LOG_DEPTH].valid) begin
            done         <= 1'b1;
            status       <= tok_ctl[LOG_DEPTH].status;
            mapped_index <= (tok_ctl[LOG_DEPTH].status == ST_OK) ?
                            tok_pos[LOG_DEPTH] : '0;
            log_length   <= count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(LOG_DEPTH))
  `ASSERT_NEXT(a_map_done, clk, rst, busy && tok_ctl[LOG_DEPTH].valid, done && !busy)
  `ASSERT_NEXT(a_map_launch, clk, rst, accept && fn == FN_MAP && !range_bad, busy && !done)
  `ASSERT_IMPL(a_err_zero, clk, rst, done && status != ST_OK, mapped_index == '0)

endmodule

// ===== design/elrm_cell.sv =====
module elrm_cell #(
  parameter int INDEX_BITS = 16,
  parameter int CNT_W      = 9,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CNT_W-1:0]      wr_ptr,
  input  logic                  wr_remove,
  input  logic [INDEX_BITS-1:0] wr_start,
  input  logic [INDEX_BITS-1:0] wr_len,
  input  logic [CNT_W-1:0]      from_q,
  input  logic [CNT_W-1:0]      to_q,
  input  elrm_pkg::tok_ctl_t    in_ctl,
  input  logic [INDEX_BITS-1:0] in_pos,
  output elrm_pkg::tok_ctl_t    out_ctl,
  output logic [INDEX_BITS-1:0] out_pos
);
  import elrm_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

  logic                  ent_remove;
  logic [INDEX_BITS-1:0] ent_start;
  logic [INDEX_BITS-1:0] ent_len;

  logic                  hit;
  logic [INDEX_BITS:0]   sum;
  logic [INDEX_BITS:0]   lim;
  tok_ctl_t              ctl_next;
  logic [INDEX_BITS-1:0] pos_next;

  always_ff @(posedge clk) begin
    if (wr_en && wr_ptr == IDX) begin
      ent_remove <= wr_remove;
      ent_start  <= wr_start;
      ent_len    <= wr_len;
    end
  end

  always_comb begin
    sum      = {1'b0, in_pos} + {1'b0, ent_len};
    lim      = {1'b0, ent_start} + {1'b0, ent_len};
    hit      = in_ctl.valid && in_ctl.status == ST_OK && IDX >= from_q && IDX < to_q &&
               in_pos >= ent_start;
    ctl_next = in_ctl;
    pos_next = in_pos;
    if (hit) begin
      if (!ent_remove) begin
        if (sum[INDEX_BITS]) begin
          ctl_next.status = ST_OVERFLOW;
        end else begin
          pos_next = sum[INDEX_BITS-1:0];
        end
      end else begin
        if ({1'b0, in_pos} <= lim) begin
          ctl_next.status = ST_REMOVED;
        end else begin
          pos_next = in_pos - ent_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl_next;
    end
    out_pos <= pos_next;
  end

endmodule

// ===== tb/sv/tb_edit_log_index_remapper.sv =====
module tb_edit_log_index_remapper;
  timeunit 1ns;
  timeprecision 1ps;

  import elrm_pkg::*;

  localparam int DEPTH        = LOG_DEPTH_DEF;
  localparam int IDX_W        = INDEX_BITS_DEF;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic             is_remove;
    logic [IDX_W-1:0] at;
    logic [IDX_W-1:0] len;
  } edit_t;

  typedef struct {
    logic [IDX_W-1:0] mapped;
    status_t          st;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             start        = 1'b0;
  logic [1:0]       func         = FN_NOP;
  logic [IDX_W-1:0] op_index     = '0;
  logic [IDX_W-1:0] op_size      = '0;
  logic [CNT_W-1:0] from_version = '0;
  logic [CNT_W-1:0] to_version   = '0;
  logic [IDX_W-1:0] query_index  = '0;
  logic             busy;
  logic             done;
  logic [IDX_W-1:0] mapped_index;
  logic [2:0]       status;
  logic [CNT_W-1:0] log_length;

  edit_t       edit_history [DEPTH];
  int          history_len = 0;
  outcome_t    pending_outcomes [$];
  outcome_t    head;
  int          idle_pct = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          n_appends = 0;
  int          n_maps = 0;
  int          n_other = 0;
  int          status_seen [5] = '{default: 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  edit_log_index_remapper i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .op_index     (op_index),
    .op_size      (op_size),
    .from_version (from_version),
    .to_version   (to_version),
    .query_index  (query_index),
    .done         (done),
    .mapped_index (mapped_index),
    .status       (status),
    .log_length   (log_length)
  );

  function automatic outcome_t replay_edits(int from_v, int to_v, int q);
    outcome_t o;
    int pos;
    o.mapped = '0;
    o.st     = ST_OK;
    o.count  = CNT_W'(history_len);
    if (from_v > to_v || to_v > history_len) begin
      o.st = ST_RANGE;
      return o;
    end
    pos = q;
    for (int i = from_v; i < to_v && o.st == ST_OK; i++) begin
      if (pos >= int'(edit_history[i].at)) begin
        if (!edit_history[i].is_remove) begin
          if (pos + int'(edit_history[i].len) > IDX_MAX) o.st = ST_OVERFLOW;
          else pos += int'(edit_history[i].len);
        end else if (pos <= int'(edit_history[i].at) + int'(edit_history[i].len)) begin
          o.st = ST_REMOVED;
        end else begin
          pos -= int'(edit_history[i].len);
        end
      end
    end
    if (o.st == ST_OK) o.mapped = IDX_W'(pos);
    return o;
  endfunction

  function automatic outcome_t predict_outcome(func_t f, int unsigned at, int unsigned len,
                                               int unsigned from_v, int unsigned to_v,
                                               int unsigned q);
    outcome_t o;
    o.mapped = '0;
    o.st     = ST_OK;
    if (f == FN_INS || f == FN_REM) begin
      if (history_len >= DEPTH) begin
        o.st = ST_FULL;
      end else begin
        edit_history[history_len] = '{f == FN_REM, IDX_W'(at), IDX_W'(len)};
        history_len++;
      end
    end else if (f == FN_MAP) begin
      o = replay_edits(from_v, to_v, q);
    end
    o.count = CNT_W'(history_len);
    return o;
  endfunction

  task automatic send_cmd(func_t f, int unsigned at, int unsigned len, int unsigned from_v,
                          int unsigned to_v, int unsigned q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    func         <= f;
    op_index     <= IDX_W'(at);
    op_size      <= IDX_W'(len);
    from_version <= CNT_W'(from_v);
    to_version   <= CNT_W'(to_v);
    query_index  <= IDX_W'(q);
    do @(posedge clk); while (busy);
    pending_outcomes = {pending_outcomes, predict_outcome(f, at, len, from_v, to_v, q)};
    if (f == FN_INS || f == FN_REM) n_appends++;
    else if (f == FN_MAP) n_maps++;
    else n_other++;
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] result with no transaction pending", $time);
      end else begin
        head = pending_outcomes.pop_front();
        check_field("mapped_index", head.mapped, mapped_index);
        check_field("status", head.st, status);
        check_field("log_length", head.count, log_length);
        status_seen[head.st]++;
      end
    end
  end

  task automatic send_random_append();
    func_t       f;
    int unsigned at;
    int unsigned len;
    f = ($urandom_range(1) == 0) ? FN_INS : FN_REM;
    if ($urandom_range(9) == 0) begin
      at  = $urandom_range(IDX_MAX);
      len = $urandom_range(IDX_MAX);
    end else begin
      at  = $urandom_range(300);
      len = $urandom_range(16);
    end
    send_cmd(f, at, len, $urandom_range(DEPTH), $urandom_range(DEPTH), $urandom);
  endtask

  task automatic send_random_map();
    int unsigned from_v;
    int unsigned to_v;
    int unsigned q;
    if ($urandom_range(9) == 0) begin
      if (history_len < DEPTH && $urandom_range(1) == 1) begin
        to_v   = $urandom_range(DEPTH, history_len + 1);
        from_v = $urandom_range(to_v);
      end else begin
        to_v   = $urandom_range((history_len < DEPTH) ? history_len : DEPTH - 1);
        from_v = $urandom_range(DEPTH, to_v + 1);
      end
    end else begin
      to_v   = $urandom_range(history_len);
      from_v = ($urandom_range(3) == 0) ? 0 : $urandom_range(to_v);
    end
    q = ($urandom_range(99) < 85) ? $urandom_range(400) : $urandom_range(IDX_MAX);
    send_cmd(FN_MAP, $urandom, $urandom, from_v, to_v, q);
  endtask

  task automatic test_empty_log();
    idle_pct = 0;
    send_cmd(FN_NOP, IDX_MAX, IDX_MAX, DEPTH, DEPTH, IDX_MAX);
    send_cmd(FN_MAP, 0, 0, 0, 0, IDX_MAX);
    send_cmd(FN_MAP, 0, 0, 0, 1, 5);
    send_cmd(FN_MAP, 0, 0, DEPTH, DEPTH, 5);
  endtask

  task automatic test_insert_shift();
    send_cmd(FN_INS, 10, 5, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 1, 0, 10);
    send_cmd(FN_MAP, 0, 0, 0, 1, 10);
    send_cmd(FN_MAP, 0, 0, 0, 1, 9);
    send_cmd(FN_MAP, 0, 0, 0, 1, IDX_MAX - 4);
    send_cmd(FN_MAP, 0, 0, 0, 1, IDX_MAX - 5);
  endtask

  task automatic test_remove_boundary();
    send_cmd(FN_REM, 20, 3, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 1, 2, 19);
    send_cmd(FN_MAP, 0, 0, 1, 2, 20);
    send_cmd(FN_MAP, 0, 0, 1, 2, 23);
    send_cmd(FN_MAP, 0, 0, 1, 2, 24);
    send_cmd(FN_MAP, 0, 0, 0, 2, 15);
  endtask

  task automatic test_extremes();
    send_cmd(FN_INS, IDX_MAX, IDX_MAX, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 2, 3, IDX_MAX);
    send_cmd(FN_MAP, 0, 0, 2, 3, IDX_MAX - 1);
    send_cmd(FN_REM, IDX_MAX, IDX_MAX, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 3, 4, IDX_MAX);
    send_cmd(FN_MAP, 0, 0, 1, 1, 123);
    send_cmd(FN_MAP, 0, 0, 4, 4, 0);
    send_cmd(FN_INS, 0, 0, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 0, 5, 0);
  endtask

  task automatic test_random_mix(int n, int idle);
    int unsigned r;
    idle_pct = idle;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_random_append();
      else if (r < 97) send_random_map();
      else send_cmd(FN_NOP, $urandom, $urandom, $urandom_range(DEPTH),
                    $urandom_range(DEPTH), $urandom);
    end
  endtask

  task automatic test_log_full();
    idle_pct = 16;
    while (history_len < DEPTH) send_random_append();
    send_cmd(FN_INS, 1, 1, 0, 0, 0);
    send_cmd(FN_REM, 1, 1, 0, 0, 0);
    send_cmd(FN_MAP, 0, 0, 0, DEPTH, $urandom_range(400));
    send_cmd(FN_MAP, 0, 0, 0, DEPTH, 0);
    send_cmd(FN_MAP, 0, 0, DEPTH - 1, DEPTH, $urandom_range(IDX_MAX));
    send_cmd(FN_MAP, 0, 0, DEPTH, DEPTH, IDX_MAX);
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_edit_log_index_remapper: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_log();
    test_insert_shift();
    test_remove_boundary();
    test_extremes();
    test_random_mix(260, 0);
    test_random_mix(260, 83);
    test_random_mix(260, 16);
    test_log_full();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    $display("covered %0d transactions: %0d appends, %0d mappings, %0d unused codes",
             n_appends + n_maps + n_other, n_appends, n_maps, n_other);
    $display("status counts: ok %0d, removed %0d, overflow %0d, full %0d, bad range %0d",
             status_seen[ST_OK], status_seen[ST_REMOVED], status_seen[ST_OVERFLOW],
             status_seen[ST_FULL], status_seen[ST_RANGE]);
    if (mismatch_count == 0) begin
      $display("tb_edit_log_index_remapper: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_edit_log_index_remapper: done, errors");
    end
    $finish;
  end

endmodule
